// ===== hdl/hlrs_pkg.sv =====
`timescale 1ns / 1ps
package hlrs_pkg;
  localparam int MaxFeatures = 64;
  localparam int CntW = $clog2(MaxFeatures + 1);
  localparam int IdxW = 6;
  localparam int NumW = 48;
  localparam int QuoW = 54;

  typedef enum logic [2:0] {
    REG_AB = 3'd0, REG_CD = 3'd1, REG_EF = 3'd2, REG_GH = 3'd3,
    REG_I = 3'd4, REG_LIMIT = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SUM, ST_DIV, ST_ERR, ST_UPD
  } eng_state_t;

  typedef struct packed {
    logic [9:0]  grid_col;
    logic [9:0]  grid_row;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [IdxW-1:0] worst_index;
    logic [31:0]     worst_error;
    logic            remove_flag;
  } result_t;
endpackage

// ===== hdl/hlrs_if.sv =====
`timescale 1ns / 1ps
interface hlrs_in_if;
  logic valid;
  logic ready;
  logic [9:0] grid_col;
  logic [9:0] grid_row;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic last;
  modport source (output valid, grid_col, grid_row, pixel_x, pixel_y, last, input ready);
  modport sink (input valid, grid_col, grid_row, pixel_x, pixel_y, last, output ready);
endinterface

interface hlrs_out_if;
  logic valid;
  logic ready;
  logic [5:0] worst_index;
  logic [31:0] worst_error;
  logic remove_flag;
  modport source (output valid, worst_index, worst_error, remove_flag, input ready);
  modport sink (input valid, worst_index, worst_error, remove_flag, output ready);
endinterface

interface hlrs_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/homography_largest_residual_select.sv =====
`timescale 1ns / 1ps
// channel | dir | beat
// in_     | in  | grid_col, grid_row, pixel_x, pixel_y, last
// out_    | out | worst_index, worst_error, remove_flag (one beat per set)
// cfg_    | in  | index, data (register write)
// The engine accepts an item, runs the three multiply and sum passes, then the
// bit-serial divider (54 steps) once for x and once for y, then error and
// update, before it accepts the next. Front queue holds two items. rst_n is
// synchronous; it restores the identity matrix and a limit
// of 4.0. A stalled result holds the engine; the queue still takes items.
module homography_largest_residual_select (
  input logic clk,
  input logic rst_n,
  hlrs_in_if.sink   in_ch,
  hlrs_out_if.source out_ch,
  hlrs_cfg_if.sink  cfg_ch
);
  logic [63:0] ab_r, cd_r, ef_r, gh_r;
  logic [31:0] i_r, lim_r;
  logic [31:0] coef [9];
  hlrs_pkg::item_t in_item, q_item;
  hlrs_pkg::result_t res;
  logic q_valid, q_ready;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ab_r <= 64'd4503599627370496; cd_r <= '0;
      ef_r <= 64'd4503599627370496; gh_r <= '0;
      i_r <= 32'd1048576; lim_r <= 32'd1024;
    end else if (cfg_ch.valid) begin
      case (hlrs_pkg::reg_idx_t'(cfg_ch.index))
        hlrs_pkg::REG_AB: ab_r <= cfg_ch.data;
        hlrs_pkg::REG_CD: cd_r <= cfg_ch.data;
        hlrs_pkg::REG_EF: ef_r <= cfg_ch.data;
        hlrs_pkg::REG_GH: gh_r <= cfg_ch.data;
        hlrs_pkg::REG_I: i_r <= cfg_ch.data[31:0];
        hlrs_pkg::REG_LIMIT: lim_r <= cfg_ch.data[31:0];
        default: ;
      endcase
    end
  end

  assign coef[0] = ab_r[63:32]; assign coef[1] = ab_r[31:0];
  assign coef[2] = cd_r[63:32]; assign coef[3] = cd_r[31:0];
  assign coef[4] = ef_r[63:32]; assign coef[5] = ef_r[31:0];
  assign coef[6] = gh_r[63:32]; assign coef[7] = gh_r[31:0];
  assign coef[8] = i_r;

  assign in_item = '{grid_col: in_ch.grid_col, grid_row: in_ch.grid_row,
                     pixel_x: in_ch.pixel_x, pixel_y: in_ch.pixel_y, last: in_ch.last};

  hlrs_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(in_ch.valid), .wr_ready(in_ch.ready),
    .wr_data(in_item), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_item)
  );

  hlrs_engine u_eng (
    .clk(clk), .rst_n(rst_n), .in_valid(q_valid), .in_ready(q_ready), .item(q_item),
    .coef(coef), .limit(lim_r), .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .res(res)
  );

  assign out_ch.worst_index = res.worst_index;
  assign out_ch.worst_error = res.worst_error;
  assign out_ch.remove_flag = res.remove_flag;

`ifndef SYNTHESIS
  a_no_flag_without_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.remove_flag |-> out_ch.worst_error > lim_r)
    else $error("remove flag without error above limit");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.worst_error))
    else $error("result dropped while stalled");
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !q_ready)
    else $error("engine took item while result pending");
`endif
endmodule

// ===== hdl/hlrs_fifo.sv =====
`timescale 1ns / 1ps
module hlrs_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  hlrs_pkg::item_t       wr_data,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output hlrs_pkg::item_t       rd_data
);
  hlrs_pkg::item_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((wr_valid && wr_ready) ? 1 : 0)
                     - 2'((rd_valid && rd_ready) ? 1 : 0);
    end
  end
endmodule

// ===== hdl/hlrs_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module hlrs_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [hlrs_pkg::QuoW-1:0]    dividend,
  input  logic [hlrs_pkg::NumW-1:0]    divisor,
  output logic                         busy,
  output logic [hlrs_pkg::QuoW-1:0]    quotient
);
  localparam int CW = $clog2(hlrs_pkg::QuoW + 1);
  logic [hlrs_pkg::QuoW-1:0] q_r;
  logic [hlrs_pkg::NumW:0]   rem_r;
  logic [hlrs_pkg::NumW-1:0] dv_r;
  logic [CW-1:0]             cnt_r;
  logic [hlrs_pkg::NumW:0]   trial;

  assign busy = (cnt_r != '0);
  assign quotient = q_r;
  assign trial = {rem_r[hlrs_pkg::NumW-1:0], q_r[hlrs_pkg::QuoW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(hlrs_pkg::QuoW);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend; rem_r <= '0; dv_r <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dv_r}) begin
        rem_r <= trial - {1'b0, dv_r};
        q_r   <= {q_r[hlrs_pkg::QuoW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[hlrs_pkg::QuoW-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== hdl/hlrs_engine.sv =====
`timescale 1ns / 1ps
module hlrs_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  hlrs_pkg::item_t        item,
  input  logic [31:0]            coef [9],
  input  logic [31:0]            limit,
  output logic                   res_valid,
  input  logic                   res_ready,
  output hlrs_pkg::result_t      res
);
  localparam int NW = hlrs_pkg::NumW;
  hlrs_pkg::eng_state_t st_r, st_nxt;
  hlrs_pkg::item_t it_r;
  logic [1:0] mi_r;
  logic [1:0] ax_r;
  logic [31:0] cf_c, cf_r, cf_k;
  logic signed [42:0] pc_r, pr_r;
  logic signed [NW:0] n_r [3];
  logic signed [17:0] q4_r [2];
  logic div_busy;
  logic go, dstart_r;
  logic [hlrs_pkg::QuoW-1:0] quo;
  logic [NW-1:0] an, aw;
  logic negq;
  logic [31:0] best_r;
  logic [hlrs_pkg::IdxW-1:0] bidx_r;
  logic have_r;
  logic [hlrs_pkg::CntW-1:0] cnt_r;
  logic [33:0] err_r;
  logic signed [18:0] dx, dy;
  logic [18:0] ax, ay;
  logic [32:0] sx, sy;
  logic resv_r;
  hlrs_pkg::result_t res_r;
  logic [31:0] ec;
  logic [hlrs_pkg::QuoW-1:0] qr;
  logic [16:0] qc;

  assign in_ready = (st_r == hlrs_pkg::ST_IDLE) && !resv_r;
  assign res_valid = resv_r;
  assign res = res_r;

  // pick the coefficients of the current matrix row
  always_comb begin
    case (mi_r)
      2'd0: begin cf_c = coef[0]; cf_r = coef[1]; cf_k = coef[2]; end
      2'd1: begin cf_c = coef[3]; cf_r = coef[4]; cf_k = coef[5]; end
      default: begin cf_c = coef[6]; cf_r = coef[7]; cf_k = coef[8]; end
    endcase
  end

  // sign-magnitude of numerator and denominator (48 bits fit exactly)
  assign an = n_r[ax_r][NW] ? NW'(-n_r[ax_r]) : NW'(n_r[ax_r]);
  assign aw = n_r[2][NW] ? NW'(-n_r[2]) : NW'(n_r[2]);
  // sign of the quotient being stored: x while ax_r is 1, y while it is 2
  assign negq = (ax_r == 2'd2 ? n_r[1][NW] : n_r[0][NW]) ^ n_r[2][NW];
  assign qr = (quo + 1'b1) >> 1;
  // clip the magnitude; anything this far out saturates the square anyway
  assign qc = (qr > hlrs_pkg::QuoW'(131071)) ? 17'h1FFFF : qr[16:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      hlrs_pkg::ST_IDLE: if (in_valid && in_ready) st_nxt = hlrs_pkg::ST_MUL;
      hlrs_pkg::ST_MUL:  st_nxt = hlrs_pkg::ST_SUM;
      hlrs_pkg::ST_SUM:  st_nxt = (mi_r == 2'd2) ? hlrs_pkg::ST_DIV : hlrs_pkg::ST_MUL;
      hlrs_pkg::ST_DIV: begin
        if (!div_busy && ax_r == 2'd2) st_nxt = hlrs_pkg::ST_ERR;
      end
      hlrs_pkg::ST_ERR: st_nxt = hlrs_pkg::ST_UPD;
      hlrs_pkg::ST_UPD: st_nxt = hlrs_pkg::ST_IDLE;
      default: st_nxt = hlrs_pkg::ST_IDLE;
    endcase
  end

  assign dx = 19'(q4_r[0]) - 19'($signed({1'b0, it_r.pixel_x}));
  assign dy = 19'(q4_r[1]) - 19'($signed({1'b0, it_r.pixel_y}));
  assign ax = dx[18] ? 19'(-dx) : 19'(dx);
  assign ay = dy[18] ? 19'(-dy) : 19'(dy);
  assign sx = (ax > 19'd65535) ? 33'h1_0000_0000 : {1'b0, 32'(ax[15:0]) * 32'(ax[15:0])};
  assign sy = (ay > 19'd65535) ? 33'h1_0000_0000 : {1'b0, 32'(ay[15:0]) * 32'(ay[15:0])};
  assign ec = (err_r[33:32] != 2'b00) ? 32'hFFFF_FFFF : err_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hlrs_pkg::ST_IDLE;
      mi_r <= 2'd0; ax_r <= 2'd0;
      best_r <= '0; bidx_r <= '0; have_r <= 1'b0; cnt_r <= '0;
      resv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (resv_r && res_ready) resv_r <= 1'b0;
      unique case (st_r)
        hlrs_pkg::ST_IDLE: begin
          if (in_valid && in_ready) begin
            it_r <= item; mi_r <= 2'd0; ax_r <= 2'd0;
          end
        end
        hlrs_pkg::ST_MUL: begin
          pc_r <= $signed(cf_c) * $signed({1'b0, it_r.grid_col});
          pr_r <= $signed(cf_r) * $signed({1'b0, it_r.grid_row});
        end
        hlrs_pkg::ST_SUM: begin
          n_r[mi_r] <= (NW+1)'(pc_r) + (NW+1)'(pr_r) + (NW+1)'($signed({cf_k, 1'b0}));
          mi_r <= (mi_r == 2'd2) ? 2'd0 : mi_r + 2'd1;
        end
        hlrs_pkg::ST_DIV: begin
          if (!div_busy) begin
            if (ax_r != 2'd0) begin
              q4_r[ax_r[1]] <= (aw == '0) ? 18'sd0 :
                (negq ? -18'(qc) : 18'(qc));
            end
            if (ax_r != 2'd2) ax_r <= ax_r + 2'd1;
          end
        end
        hlrs_pkg::ST_ERR: err_r <= 34'(sx) + 34'(sy);
        hlrs_pkg::ST_UPD: begin
          if (it_r.last) begin
            if (cnt_r < hlrs_pkg::CntW'(hlrs_pkg::MaxFeatures) && ec > best_r) begin
              res_r.worst_index <= hlrs_pkg::IdxW'(cnt_r);
              res_r.worst_error <= ec;
              res_r.remove_flag <= ec > limit;
            end else begin
              res_r.worst_index <= have_r ? bidx_r : '0;
              res_r.worst_error <= have_r ? best_r : '0;
              res_r.remove_flag <= have_r && (best_r > limit);
            end
            resv_r <= 1'b1;
            best_r <= '0; bidx_r <= '0; have_r <= 1'b0; cnt_r <= '0;
          end else if (cnt_r < hlrs_pkg::CntW'(hlrs_pkg::MaxFeatures)) begin
            if (ec > best_r) begin
              best_r <= ec; bidx_r <= hlrs_pkg::IdxW'(cnt_r); have_r <= 1'b1;
            end
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // divide issue: start on the first DIV cycle for x, then for y
  assign go = (st_r == hlrs_pkg::ST_DIV) && !div_busy && (ax_r != 2'd2) && !dstart_r;
  always_ff @(posedge clk) begin
    if (!rst_n) dstart_r <= 1'b0;
    else dstart_r <= go;
  end

  hlrs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(go),
    .dividend(hlrs_pkg::QuoW'({an, 5'b0})),
    .divisor(aw == '0 ? NW'(1) : aw),
    .busy(div_busy), .quotient(quo)
  );
endmodule

// ===== test/homography_largest_residual_select_tb.sv =====
`timescale 1ns / 1ps
module homography_largest_residual_select_tb;

  // An index past the register list; a write there must change nothing.
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int DrainCycles = 400;
  localparam int QuietLimit = 30000;
  localparam logic [31:0] Q20One = 32'h0010_0000;

  logic clk;
  logic rst_n;

  hlrs_in_if  in_ch ();
  hlrs_out_if out_ch ();
  hlrs_cfg_if cfg_ch ();

  homography_largest_residual_select uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow registers, reset to the identity matrix and a 4.0 limit.
  logic [63:0] shadow_reg [6] = '{{Q20One, 32'h0}, 64'h0, {Q20One, 32'h0}, 64'h0,
                                  {32'h0, Q20One}, 64'd1024};

  // Running worst-residual state of the set in flight.
  logic [31:0] worst_err_q = '0;
  logic [5:0]  worst_pos_q = '0;
  logic        worst_seen_q = 1'b0;
  int unsigned set_pos_q = 0;

  hlrs_pkg::result_t pending_results [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  // Sign-extend one Q12.20 coefficient.
  function automatic longint coef(input logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  // round(16 * n / w), half away from zero; zero denominator gives 0.
  function automatic longint to_q4(input longint n, input longint w);
    bit [63:0] an;
    bit [63:0] aw;
    bit [63:0] q;
    if (w == 0) return 0;
    an = (n < 0) ? -n : n;
    aw = (w < 0) ? -w : w;
    q  = (((an << 5) / aw) + 1) >> 1;
    return ((n < 0) != (w < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // Project a grid point into Q4 pixel coordinates with the shadow matrix.
  task automatic project(input logic [9:0] gc, input logic [9:0] gr,
                         output longint qx, output longint qy);
    longint c;
    longint r;
    longint nx;
    longint ny;
    longint w;
    c  = longint'(gc);
    r  = longint'(gr);
    nx = coef(shadow_reg[hlrs_pkg::REG_AB][63:32]) * c
       + coef(shadow_reg[hlrs_pkg::REG_AB][31:0]) * r
       + 2 * coef(shadow_reg[hlrs_pkg::REG_CD][63:32]);
    ny = coef(shadow_reg[hlrs_pkg::REG_CD][31:0]) * c
       + coef(shadow_reg[hlrs_pkg::REG_EF][63:32]) * r
       + 2 * coef(shadow_reg[hlrs_pkg::REG_EF][31:0]);
    w  = coef(shadow_reg[hlrs_pkg::REG_GH][63:32]) * c
       + coef(shadow_reg[hlrs_pkg::REG_GH][31:0]) * r
       + 2 * coef(shadow_reg[hlrs_pkg::REG_I][31:0]);
    qx = to_q4(nx, w);
    qy = to_q4(ny, w);
  endtask

  function automatic longint square_clip(input longint d);
    longint a;
    a = (d < 0) ? -d : d;
    return (a > 65535) ? 64'h1_0000_0000 : a * a;
  endfunction

  task automatic residual(input hlrs_pkg::item_t it, output logic [31:0] err);
    longint qx;
    longint qy;
    longint e;
    project(it.grid_col, it.grid_row, qx, qy);
    e = square_clip(qx - longint'(it.pixel_x)) + square_clip(qy - longint'(it.pixel_y));
    err = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Track each accepted item and queue the set result when it ends.
  always @(posedge clk) begin
    hlrs_pkg::item_t   it;
    logic [31:0]       err;
    hlrs_pkg::result_t r;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it = '{in_ch.grid_col, in_ch.grid_row, in_ch.pixel_x, in_ch.pixel_y, in_ch.last};
      residual(it, err);
      if (set_pos_q < hlrs_pkg::MaxFeatures) begin
        if (err > worst_err_q) begin
          worst_err_q  = err;
          worst_pos_q  = set_pos_q[5:0];
          worst_seen_q = 1'b1;
        end
        set_pos_q++;
      end
      if (it.last) begin
        r.worst_index = worst_seen_q ? worst_pos_q : '0;
        r.worst_error = worst_seen_q ? worst_err_q : '0;
        r.remove_flag = worst_seen_q
                        && (worst_err_q > shadow_reg[hlrs_pkg::REG_LIMIT][31:0]);
        pending_results = {pending_results, r};
        worst_err_q  = '0;
        worst_pos_q  = '0;
        worst_seen_q = 1'b0;
        set_pos_q    = 0;
      end
    end
  end

  // Mirror register writes; unknown indexes drop silently.
  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index) inside
        hlrs_pkg::REG_AB, hlrs_pkg::REG_CD, hlrs_pkg::REG_EF, hlrs_pkg::REG_GH:
          shadow_reg[cfg_ch.index] <= cfg_ch.data;
        hlrs_pkg::REG_I, hlrs_pkg::REG_LIMIT:
          shadow_reg[cfg_ch.index] <= {32'h0, cfg_ch.data[31:0]};
        default: ;
      endcase
    end
  end

  // Compare each result beat against the oldest expectation.
  always @(posedge clk) begin
    hlrs_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.worst_index, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.worst_index !== want.worst_index)
          report_mismatch("worst_index", out_ch.worst_index, want.worst_index);
        if (out_ch.worst_error !== want.worst_error)
          report_mismatch("worst_error", out_ch.worst_error, want.worst_error);
        if (out_ch.remove_flag !== want.remove_flag)
          report_mismatch("remove_flag", out_ch.remove_flag, want.remove_flag);
      end
    end
  end

  // Stall the result channel at the current rate.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // End the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Send one item; idle first at the current rate, keep valid high when not.
  task automatic send_item(input hlrs_pkg::item_t it);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.grid_col <= it.grid_col;
    in_ch.grid_row <= it.grid_row;
    in_ch.pixel_x  <= it.pixel_x;
    in_ch.pixel_y  <= it.pixel_y;
    in_ch.last     <= it.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic release_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every set has reported and the engine has drained.
  task automatic wait_idle();
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write all six registers back to back, then the unused index.
  task automatic load_regs(input logic [63:0] ab, input logic [63:0] cd,
                           input logic [63:0] ef, input logic [63:0] gh,
                           input logic [31:0] ci, input logic [31:0] lim);
    logic [63:0] vals [6];
    vals = '{ab, cd, ef, gh, {32'h0, ci}, {32'h0, lim}};
    for (int k = 0; k < 6; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= hlrs_pkg::reg_idx_t'(k);
      cfg_ch.data  <= vals[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.index <= RegUnused;
    cfg_ch.data  <= {$urandom, $urandom};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Pick one of the matrix settings, the extremes among them.
  task automatic apply_setting(input int k);
    case (k)
      0: load_regs({Q20One, 32'h0}, 64'h0, {Q20One, 32'h0}, 64'h0, Q20One, 32'd1024);
      1: load_regs({32'h0030_0000, 32'h0000_8000}, {32'h00A0_0000, 32'hFFFF_8000},
                   {32'h0028_0000, 32'h0140_0000}, 64'h0, Q20One, 32'd0);
      2: load_regs({Q20One, 32'h0}, {32'h0080_0000, 32'h0},
                   {Q20One, 32'h0040_0000}, {32'h0000_0064, 32'hFFFF_FFCE},
                   Q20One, 32'd4096);
      // Zero denominator: every projection collapses to the origin.
      3: load_regs({32'h0123_4567, 32'h0}, 64'h0, {32'h0200_0000, 32'h0}, 64'h0,
                   32'h0, 32'hFFFF_FFFF);
      4: load_regs('1, '1, '1, '1, 32'h8000_0000, 32'hFFFF_FFFF);
      default: load_regs({32'h8000_0000, 32'h7FFF_FFFF}, {32'h7FFF_FFFF, 32'h8000_0000},
                         {32'h8000_0000, 32'h7FFF_FFFF}, {32'h7FFF_FFFF, 32'h8000_0000},
                         32'h7FFF_FFFF, 32'd1);
    endcase
  endtask

  function automatic logic [15:0] clamp16(input longint v);
    if (v < 0) return 16'h0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // Mostly near-miss observations so sets carry small, close errors.
  task automatic make_item(input logic last, output hlrs_pkg::item_t it);
    longint qx;
    longint qy;
    it.grid_col = $urandom_range(1023);
    it.grid_row = $urandom_range(1023);
    it.last     = last;
    if ($urandom_range(9) < 7) begin
      project(it.grid_col, it.grid_row, qx, qy);
      it.pixel_x = clamp16(qx + longint'($urandom_range(80)) - 40);
      it.pixel_y = clamp16(qy + longint'($urandom_range(80)) - 40);
    end else begin
      it.pixel_x = $urandom_range(65535);
      it.pixel_y = $urandom_range(65535);
    end
  endtask

  task automatic test_directed();
    // Identity: the prediction of grid (c, r) is (8c, 8r) in Q4.
    send_item('{10'd0, 10'd0, 16'd0, 16'd0, 1'b1});             // all errors zero
    send_item('{10'd1023, 10'd1023, 16'd0, 16'd0, 1'b1});       // big lone error
    send_item('{10'd0, 10'd0, 16'hFFFF, 16'hFFFF, 1'b1});       // saturating error
    send_item('{10'd4, 10'd4, 16'd32, 16'd32, 1'b0});           // zero error
    send_item('{10'd4, 10'd4, 16'd33, 16'd32, 1'b0});           // error 1
    send_item('{10'd4, 10'd4, 16'd31, 16'd32, 1'b0});           // tie keeps first
    send_item('{10'd4, 10'd4, 16'd64, 16'd32, 1'b1});           // error 1024, at limit
    send_item('{10'd4, 10'd4, 16'd65, 16'd32, 1'b1});           // just above limit
    send_item('{10'd1023, 10'd0, 16'h1FF8, 16'hFFFF, 1'b0});
    send_item('{10'd0, 10'd1023, 16'hFFFF, 16'h1FF8, 1'b0});
    send_item('{10'd512, 10'd512, 16'h1000, 16'h1000, 1'b1});
    send_item('{10'd341, 10'd682, 16'h5555, 16'hAAAA, 1'b0});
    send_item('{10'd682, 10'd341, 16'hAAAA, 16'h5555, 1'b1});
    wait_idle();
  endtask

  // More items than the set can track; the tail is accepted but not ranked.
  task automatic test_long_set();
    hlrs_pkg::item_t it;
    for (int n = 0; n < hlrs_pkg::MaxFeatures + 6; n++) begin
      make_item(n == hlrs_pkg::MaxFeatures + 5, it);
      if (n >= hlrs_pkg::MaxFeatures) it.pixel_x = 16'hFFFF;
      send_item(it);
    end
    wait_idle();
  endtask

  task automatic test_random_sets(input int items);
    hlrs_pkg::item_t it;
    int    left;
    int    sz;
    left = items;
    while (left > 0) begin
      sz = ($urandom_range(9) == 0) ? $urandom_range(hlrs_pkg::MaxFeatures + 4, 1)
                                    : $urandom_range(12, 1);
      if (sz > left) sz = left;
      for (int n = 0; n < sz; n++) begin
        make_item(n == sz - 1, it);
        send_item(it);
      end
      left -= sz;
    end
    wait_idle();
  endtask

  initial begin
    int idle_mode [4][2];
    idle_mode = '{'{0, 0}, '{67, 0}, '{0, 67}, '{28, 28}};
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.grid_col = '0;
    in_ch.grid_row = '0;
    in_ch.pixel_x = '0;
    in_ch.pixel_y = '0;
    in_ch.last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = hlrs_pkg::REG_AB;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_long_set();
    // Walk every setting under every idling pattern.
    for (int k = 0; k < 6; k++) begin
      for (int m = 0; m < 4; m++) begin
        apply_setting(k);
        sender_idle_pct = idle_mode[m][0];
        receiver_stall_pct = idle_mode[m][1];
        test_random_sets(62);
      end
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    apply_setting(0);
    test_random_sets(20);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/hlrs_pkg.sv
hdl/hlrs_if.sv
hdl/hlrs_fifo.sv
hdl/hlrs_div.sv
hdl/hlrs_engine.sv
hdl/homography_largest_residual_select.sv
test/homography_largest_residual_select_tb.sv
